FILE: src/lrfbs_pkg.sv
// Shared types, codes and constants for the rectangle fill byte sequencer.
package lrfbs_pkg;

  // Pixels per chip-select frame in the pixel phase
  localparam int CHUNK_PIXELS = 256;
  localparam int CHUNK_W      = (CHUNK_PIXELS > 1) ? $clog2(CHUNK_PIXELS) : 1;

  // Display command bytes
  localparam logic [7:0] CMD_CASET = 8'h2A;
  localparam logic [7:0] CMD_RASET = 8'h2B;
  localparam logic [7:0] CMD_RAMWR = 8'h2C;

  // Item function codes
  localparam logic FUNC_START   = 1'b0;
  localparam logic FUNC_ADVANCE = 1'b1;

  // Result status codes
  localparam logic [2:0] ST_BYTE     = 3'd0;
  localparam logic [2:0] ST_ACCEPTED = 3'd1;
  localparam logic [2:0] ST_INVALID  = 3'd2;
  localparam logic [2:0] ST_BUSY     = 3'd3;
  localparam logic [2:0] ST_IDLE     = 3'd4;

  // Header positions; HDR_PIXELS marks the pixel phase
  localparam logic [3:0] HDR_CASET   = 4'd0;
  localparam logic [3:0] HDR_CS_HI   = 4'd1;
  localparam logic [3:0] HDR_CS_LO   = 4'd2;
  localparam logic [3:0] HDR_CE_HI   = 4'd3;
  localparam logic [3:0] HDR_CE_LO   = 4'd4;
  localparam logic [3:0] HDR_RASET   = 4'd5;
  localparam logic [3:0] HDR_RS_HI   = 4'd6;
  localparam logic [3:0] HDR_RS_LO   = 4'd7;
  localparam logic [3:0] HDR_RE_HI   = 4'd8;
  localparam logic [3:0] HDR_RE_LO   = 4'd9;
  localparam logic [3:0] HDR_RAMWR   = 4'd10;
  localparam logic [3:0] HDR_PIXELS  = 4'd11;

  // Register indexes
  localparam logic [1:0] REG_PANEL_WIDTH   = 2'd0;
  localparam logic [1:0] REG_PANEL_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_COLUMN_OFFSET = 2'd2;
  localparam logic [1:0] REG_ROW_OFFSET    = 2'd3;

  typedef struct packed {
    logic [8:0] panel_width;
    logic [8:0] panel_height;
    logic [7:0] column_offset;
    logic [7:0] row_offset;
  } cfg_t;

  typedef struct packed {
    logic        func;
    logic [15:0] rect_x;
    logic [15:0] rect_y;
    logic [15:0] rect_width;
    logic [15:0] rect_height;
    logic [15:0] fill_color;
  } item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] out_byte;
    logic       is_data;
    logic       transfer_end;
    logic       fill_last;
  } res_t;

endpackage

FILE: src/lrfbs_cfg.sv
// APB register file holding panel size and address offsets.
module lrfbs_cfg (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output lrfbs_pkg::cfg_t     cfg
);
  import lrfbs_pkg::*;

  logic       wr_en;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  // Write registers on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.panel_width   <= 9'd240;
      cfg.panel_height  <= 9'd280;
      cfg.column_offset <= 8'd0;
      cfg.row_offset    <= 8'd20;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_PANEL_WIDTH:   cfg.panel_width   <= pwdata[8:0];
        REG_PANEL_HEIGHT:  cfg.panel_height  <= pwdata[8:0];
        REG_COLUMN_OFFSET: cfg.column_offset <= pwdata[7:0];
        REG_ROW_OFFSET:    cfg.row_offset    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Return the addressed register
  always_comb begin
    unique case (reg_sel)
      REG_PANEL_WIDTH:   prdata = {23'd0, cfg.panel_width};
      REG_PANEL_HEIGHT:  prdata = {23'd0, cfg.panel_height};
      REG_COLUMN_OFFSET: prdata = {24'd0, cfg.column_offset};
      REG_ROW_OFFSET:    prdata = {24'd0, cfg.row_offset};
      default:           prdata = 32'd0;
    endcase
  end

endmodule

FILE: src/lrfbs_seq.sv
// Fill state and per-item result logic: window check, header bytes, pixel bytes.
module lrfbs_seq (
  input  logic              clk,
  input  logic              rst,
  input  lrfbs_pkg::cfg_t   cfg,
  input  logic              fire,
  input  lrfbs_pkg::item_t  item,
  output lrfbs_pkg::res_t   res
);
  import lrfbs_pkg::*;

  localparam logic [CHUNK_W:0] CHUNK_LIMIT = (CHUNK_W + 1)'(CHUNK_PIXELS);

  logic               busy, busy_next;
  logic [3:0]         header_index, header_index_next;
  logic [15:0]        col_start_addr, col_start_addr_next;
  logic [15:0]        col_end_addr, col_end_addr_next;
  logic [15:0]        row_start_addr, row_start_addr_next;
  logic [15:0]        row_end_addr, row_end_addr_next;
  logic [15:0]        held_color, held_color_next;
  logic [17:0]        pixels_left, pixels_left_next;
  logic [CHUNK_W-1:0] chunk_pixels_sent, chunk_pixels_sent_next;
  logic               low_byte_next, low_byte_next_next;

  logic [15:0] pw16, ph16, room_x, room_y;
  logic        rect_ok;
  logic [17:0] area;
  logic        last_pixel, chunk_full;
  logic [CHUNK_W:0] chunk_inc;

  // Check the rectangle against the panel without overflow
  always_comb begin
    pw16    = {7'd0, cfg.panel_width};
    ph16    = {7'd0, cfg.panel_height};
    room_x  = pw16 - item.rect_x;
    room_y  = ph16 - item.rect_y;
    rect_ok = (item.rect_width != 16'd0) && (item.rect_height != 16'd0) &&
              (item.rect_x < pw16) && (item.rect_y < ph16) &&
              (item.rect_width <= room_x) && (item.rect_height <= room_y);
    area    = 18'(item.rect_width[8:0]) * 18'(item.rect_height[8:0]);
  end

  // Pixel phase frame and fill end flags
  always_comb begin
    chunk_inc  = {1'b0, chunk_pixels_sent} + (CHUNK_W + 1)'(1);
    last_pixel = (pixels_left <= 18'd1);
    chunk_full = (chunk_inc >= CHUNK_LIMIT);
  end

  // Result and next state for the item in hand
  always_comb begin
    busy_next              = busy;
    header_index_next      = header_index;
    col_start_addr_next    = col_start_addr;
    col_end_addr_next      = col_end_addr;
    row_start_addr_next    = row_start_addr;
    row_end_addr_next      = row_end_addr;
    held_color_next        = held_color;
    pixels_left_next       = pixels_left;
    chunk_pixels_sent_next = chunk_pixels_sent;
    low_byte_next_next     = low_byte_next;
    res                    = '0;

    if (item.func == FUNC_START) begin
      if (busy) begin
        res.status = ST_BUSY;
      end else if (!rect_ok) begin
        res.status = ST_INVALID;
      end else begin
        res.status             = ST_ACCEPTED;
        col_start_addr_next    = item.rect_x + {8'd0, cfg.column_offset};
        col_end_addr_next      = item.rect_x + item.rect_width - 16'd1 +
                                 {8'd0, cfg.column_offset};
        row_start_addr_next    = item.rect_y + {8'd0, cfg.row_offset};
        row_end_addr_next      = item.rect_y + item.rect_height - 16'd1 +
                                 {8'd0, cfg.row_offset};
        held_color_next        = item.fill_color;
        pixels_left_next       = area;
        chunk_pixels_sent_next = '0;
        low_byte_next_next     = 1'b0;
        header_index_next      = HDR_CASET;
        busy_next              = 1'b1;
      end
    end else if (!busy) begin
      res.status = ST_IDLE;
    end else if (header_index != HDR_PIXELS) begin
      // Emit the window header, one byte per item
      res.status        = ST_BYTE;
      res.is_data       = 1'b1;
      header_index_next = header_index + 4'd1;
      unique case (header_index)
        HDR_CASET: begin
          res.out_byte     = CMD_CASET;
          res.is_data      = 1'b0;
          res.transfer_end = 1'b1;
        end
        HDR_CS_HI: res.out_byte = col_start_addr[15:8];
        HDR_CS_LO: res.out_byte = col_start_addr[7:0];
        HDR_CE_HI: res.out_byte = col_end_addr[15:8];
        HDR_CE_LO: begin
          res.out_byte     = col_end_addr[7:0];
          res.transfer_end = 1'b1;
        end
        HDR_RASET: begin
          res.out_byte     = CMD_RASET;
          res.is_data      = 1'b0;
          res.transfer_end = 1'b1;
        end
        HDR_RS_HI: res.out_byte = row_start_addr[15:8];
        HDR_RS_LO: res.out_byte = row_start_addr[7:0];
        HDR_RE_HI: res.out_byte = row_end_addr[15:8];
        HDR_RE_LO: begin
          res.out_byte     = row_end_addr[7:0];
          res.transfer_end = 1'b1;
        end
        default: begin
          res.out_byte     = CMD_RAMWR;
          res.is_data      = 1'b0;
          res.transfer_end = 1'b1;
        end
      endcase
    end else if (!low_byte_next) begin
      // High colour byte
      res.status         = ST_BYTE;
      res.out_byte       = held_color[15:8];
      res.is_data        = 1'b1;
      low_byte_next_next = 1'b1;
    end else begin
      // Low colour byte closes the pixel
      res.status             = ST_BYTE;
      res.out_byte           = held_color[7:0];
      res.is_data            = 1'b1;
      res.transfer_end       = last_pixel || chunk_full;
      res.fill_last          = last_pixel;
      low_byte_next_next     = 1'b0;
      chunk_pixels_sent_next = chunk_full ? '0 : chunk_inc[CHUNK_W-1:0];
      if (last_pixel) begin
        pixels_left_next       = '0;
        chunk_pixels_sent_next = '0;
        header_index_next      = HDR_CASET;
        busy_next              = 1'b0;
      end else begin
        pixels_left_next = pixels_left - 18'd1;
      end
    end
  end

  // Hold state between items, advance on each fired item
  always_ff @(posedge clk) begin
    if (rst) begin
      busy              <= 1'b0;
      header_index      <= HDR_CASET;
      col_start_addr    <= '0;
      col_end_addr      <= '0;
      row_start_addr    <= '0;
      row_end_addr      <= '0;
      held_color        <= '0;
      pixels_left       <= '0;
      chunk_pixels_sent <= '0;
      low_byte_next     <= 1'b0;
    end else if (fire) begin
      busy              <= busy_next;
      header_index      <= header_index_next;
      col_start_addr    <= col_start_addr_next;
      col_end_addr      <= col_end_addr_next;
      row_start_addr    <= row_start_addr_next;
      row_end_addr      <= row_end_addr_next;
      held_color        <= held_color_next;
      pixels_left       <= pixels_left_next;
      chunk_pixels_sent <= chunk_pixels_sent_next;
      low_byte_next     <= low_byte_next_next;
    end
  end

  a_accept_sets_busy: assert property (@(posedge clk) disable iff (rst)
    (fire && res.status == ST_ACCEPTED) |=> busy && header_index == HDR_CASET)
    else $error("accepted fill did not start at the header");

  a_last_clears_busy: assert property (@(posedge clk) disable iff (rst)
    (fire && res.fill_last) |=> !busy)
    else $error("fill still busy after its last byte");

  a_header_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> header_index <= HDR_PIXELS)
    else $error("header position out of range");

  a_pixels_pending: assert property (@(posedge clk) disable iff (rst)
    (busy && header_index == HDR_PIXELS) |-> pixels_left != 18'd0)
    else $error("pixel phase with no pixels left");

endmodule

FILE: src/lcd_rect_fill_byte_sequencer.sv
// Top level of the rectangle fill byte sequencer: input and result registers.
//
// Usage: program panel_width, panel_height, column_offset and row_offset
// over the APB port while idle (reset values 240, 280, 0, 20). Send a start
// item (func 0) carrying a rectangle and an RGB565 colour; it answers
// accepted, invalid rect or busy rejected. Then send one advance item
// (func 1) per byte wanted: each answers with one byte and its DC, frame
// end and fill end flags, or idle when no fill is running.
// Every item gives exactly one result item.
// An item accepted at a clock edge sits in the input register, passes the
// window check / byte select logic and is loaded into the result register
// as soon as the result register is free, where out_valid rises.
// One item is taken per cycle while the receiver does not stall; the rate is
// set by the single state update per item in the sequencer.
// Reset clears all fill state and drops any held item or result.
// When the receiver stalls, the result register holds its item, the input
// register fills, and in_stall rises until the result is taken.
module lcd_rect_fill_byte_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [15:0] rect_x,
  input  logic [15:0] rect_y,
  input  logic [15:0] rect_width,
  input  logic [15:0] rect_height,
  input  logic [15:0] fill_color,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [7:0]  out_byte,
  output logic        is_data,
  output logic        transfer_end,
  output logic        fill_last
);
  import lrfbs_pkg::*;

  cfg_t  cfg;
  item_t in_item;
  item_t held_item;
  logic  held_valid;
  res_t  seq_res;
  res_t  out_res;
  logic  out_free;
  logic  fire;
  logic  in_take;

  lrfbs_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign in_item = '{func: func, rect_x: rect_x, rect_y: rect_y,
                     rect_width: rect_width, rect_height: rect_height,
                     fill_color: fill_color};

  assign out_free = !out_valid || !out_stall;
  assign fire     = held_valid && out_free;
  assign in_stall = held_valid && !out_free;
  assign in_take  = in_valid && !in_stall;

  // Input register: load when empty or draining
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!in_stall) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      held_item <= in_item;
    end
  end

  lrfbs_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .fire (fire),
    .item (held_item),
    .res  (seq_res)
  );

  // Result register: hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= seq_res;
    end
  end

  assign status       = out_res.status;
  assign out_byte     = out_res.out_byte;
  assign is_data      = out_res.is_data;
  assign transfer_end = out_res.transfer_end;
  assign fill_last    = out_res.fill_last;

endmodule
